/* design/vwma_pkg.sv */
// Package for the volume-weighted moving average block.
// Holds sequencer state type, field widths, reset window values and register codes; no dependencies.
package vwma_pkg;

    localparam int NUM_WIN  = 4;
    localparam int FIELD_W  = 24;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 8;
    localparam int PSUM_W   = 26;   // high + low + close
    localparam int TURN_W   = 50;   // (high + low + close) * volume
    localparam int DIV_CNT_W = 5;

    localparam logic [CFG_W-1:0] WINDOW_A_RESET = 9'd5;
    localparam logic [CFG_W-1:0] WINDOW_B_RESET = 9'd20;
    localparam logic [CFG_W-1:0] WINDOW_C_RESET = 9'd60;
    localparam logic [CFG_W-1:0] WINDOW_D_RESET = 9'd200;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_B = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_D = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RD,
        S_ADD,
        S_SUB,
        S_WR,
        S_DINIT,
        S_DIV,
        S_OUT
    } t_state;

endpackage

/* design/volume_weighted_moving_average_top.sv */
// Top level of the volume-weighted moving average over typical price.
// Depends on vwma_pkg and vwma_ram (bar history ring).
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-----------------------------------
//  bar in    | in        | i_valid / o_stall  | i_bar_high/low/close/volume
//  average   | out       | o_valid / i_stall  | o_average_a..d, o_valid_a..d
//  config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A request runs the multiply, then per window the running-sum update
// (ring read, add, subtract), the ring write, then per window a setup and
// divide in the shared restoring divider (24 quotient bits), then the output,
// held while i_stall is high. A window with no valid average skips its divide.
// Reset is synchronous, active low, restores window registers and clears history.
// o_stall is high from acceptance until the result has been taken.
module volume_weighted_moving_average_top #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [vwma_pkg::FIELD_W-1:0]   i_bar_high,
    input  logic [vwma_pkg::FIELD_W-1:0]   i_bar_low,
    input  logic [vwma_pkg::FIELD_W-1:0]   i_bar_close,
    input  logic [vwma_pkg::FIELD_W-1:0]   i_bar_volume,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vwma_pkg::FIELD_W-1:0]   o_average_a,
    output logic [vwma_pkg::FIELD_W-1:0]   o_average_b,
    output logic [vwma_pkg::FIELD_W-1:0]   o_average_c,
    output logic [vwma_pkg::FIELD_W-1:0]   o_average_d,
    output logic                           o_valid_a,
    output logic                           o_valid_b,
    output logic                           o_valid_c,
    output logic                           o_valid_d,
    input  logic                           i_cfg_we,
    input  logic [vwma_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vwma_pkg::CFG_W-1:0]     i_cfg_data
);

    import vwma_pkg::*;

    localparam int LW   = $clog2(MAX_WINDOW);      // ring index width
    localparam int WW   = $clog2(MAX_WINDOW + 1);  // window / bar count width
    localparam int AW   = WW + 1;                  // slot arithmetic width
    localparam int TSW  = TURN_W + LW;             // turnover sum width
    localparam int VSW  = FIELD_W + LW;            // volume sum width
    localparam int DW   = VSW + 2;                 // 3 * volume sum width
    localparam int RW   = TURN_W + FIELD_W;        // ring word: turnover, volume

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_win_reg [NUM_WIN];
    logic [WW-1:0]      w_eff     [NUM_WIN];
    logic [TSW-1:0]     r_tsum    [NUM_WIN];
    logic [VSW-1:0]     r_vsum    [NUM_WIN];
    logic [WW-1:0]      r_seen;
    logic [LW-1:0]      r_slot;
    logic [1:0]         r_win;
    logic [PSUM_W-1:0]  r_psum;
    logic [FIELD_W-1:0] r_vol;
    logic [TURN_W-1:0]  r_turn;
    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_dsr;
    logic [FIELD_W-1:0] r_dvd;
    logic [FIELD_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FIELD_W-1:0] r_avg [NUM_WIN];
    logic               r_ok  [NUM_WIN];
    logic               r_out_valid;

    logic [WW-1:0]  win_cur;
    logic           full_cur;
    logic           ok_cur;
    logic [AW-1:0]  slot_x, win_x, old_x;
    logic [LW-1:0]  old_slot;
    logic [RW-1:0]  ring_rdata;
    logic           ring_we;
    logic           last_win;
    logic           div_last;
    logic [DW:0]    div_r2;
    logic [DW:0]    div_diff;
    logic           div_ge;
    logic           accept;
    logic           cfg_hit;

    // Clamp each window register to the range 1 .. MAX_WINDOW.
    always_comb begin
        for (int k = 0; k < NUM_WIN; k++) begin
            if (r_win_reg[k] == '0) begin
                w_eff[k] = WW'(1);
            end else if (32'(r_win_reg[k]) > MAX_WINDOW) begin
                w_eff[k] = WW'(MAX_WINDOW);
            end else begin
                w_eff[k] = WW'(r_win_reg[k]);
            end
        end
    end

    assign win_cur  = w_eff[r_win];
    assign full_cur = (r_seen >= win_cur);               // before this bar in update phase
    assign ok_cur   = (r_seen >= win_cur) && (r_vsum[r_win] != '0);
    assign last_win = (r_win == 2'(NUM_WIN - 1));
    assign div_last = (r_cnt == DIV_CNT_W'(FIELD_W - 1));

    // Slot of the bar leaving the current window, modulo the ring depth.
    assign slot_x   = AW'(r_slot);
    assign win_x    = AW'(win_cur);
    assign old_x    = (slot_x >= win_x) ? (slot_x - win_x)
                                        : (slot_x + AW'(MAX_WINDOW) - win_x);
    assign old_slot = old_x[LW-1:0];

    // One restoring divider step.
    assign div_r2   = {r_rem, r_dvd[FIELD_W-1]};
    assign div_diff = div_r2 - {1'b0, r_dsr};
    assign div_ge   = (div_r2 >= {1'b0, r_dsr});

    assign accept  = i_valid && !o_stall;
    assign cfg_hit = i_cfg_we && (i_cfg_idx <= REG_WINDOW_D);

    vwma_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_slot),
        .i_wdata ({r_turn, r_vol}),
        .i_raddr (old_slot),
        .o_rdata (ring_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_MUL;
            S_MUL:   n_state = S_RD;
            S_RD:    n_state = S_ADD;
            S_ADD:   n_state = S_SUB;
            S_SUB:   n_state = last_win ? S_WR : S_RD;
            S_WR:    n_state = S_DINIT;
            S_DINIT: begin
                if (ok_cur) begin
                    n_state = S_DIV;
                end else begin
                    n_state = last_win ? S_OUT : S_DINIT;
                end
            end
            S_DIV:   if (div_last) n_state = last_win ? S_OUT : S_DINIT;
            S_OUT:   if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        ring_we = 1'b0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_WR:    ring_we = 1'b1;
            default: begin
                ring_we = 1'b0;
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_win_reg[0] <= WINDOW_A_RESET;
            r_win_reg[1] <= WINDOW_B_RESET;
            r_win_reg[2] <= WINDOW_C_RESET;
            r_win_reg[3] <= WINDOW_D_RESET;
            for (int k = 0; k < NUM_WIN; k++) begin
                r_tsum[k] <= '0;
                r_vsum[k] <= '0;
            end
            r_seen      <= '0;
            r_slot      <= '0;
            r_win       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_hit) begin
                // Store the register, then drop the history.
                r_win_reg[i_cfg_idx[1:0]] <= i_cfg_data;
                for (int k = 0; k < NUM_WIN; k++) begin
                    r_tsum[k] <= '0;
                    r_vsum[k] <= '0;
                end
                r_seen <= '0;
                r_slot <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    r_win <= '0;
                    if (accept) begin
                        r_psum <= PSUM_W'(i_bar_high) + PSUM_W'(i_bar_low)
                                + PSUM_W'(i_bar_close);
                        r_vol  <= i_bar_volume;
                    end
                end
                S_MUL: begin
                    r_turn <= TURN_W'(r_psum * r_vol);
                end
                S_ADD: begin
                    r_tsum[r_win] <= r_tsum[r_win] + TSW'(r_turn);
                    r_vsum[r_win] <= r_vsum[r_win] + VSW'(r_vol);
                end
                S_SUB: begin
                    // Drop the bar that leaves the window once it has filled.
                    if (full_cur) begin
                        r_tsum[r_win] <= r_tsum[r_win] - TSW'(ring_rdata[RW-1:FIELD_W]);
                        r_vsum[r_win] <= r_vsum[r_win] - VSW'(ring_rdata[FIELD_W-1:0]);
                    end
                    r_win <= r_win + 2'd1;
                end
                S_WR: begin
                    r_slot <= (r_slot == LW'(MAX_WINDOW - 1)) ? '0 : r_slot + LW'(1);
                    if (r_seen < WW'(MAX_WINDOW)) begin
                        r_seen <= r_seen + WW'(1);
                    end
                    r_win <= '0;
                end
                S_DINIT: begin
                    r_cnt <= '0;
                    r_ok[r_win] <= ok_cur;
                    if (ok_cur) begin
                        // Quotient fits in FIELD_W bits, so start from the upper bits.
                        r_rem <= r_tsum[r_win][TSW-1:FIELD_W];
                        r_dvd <= r_tsum[r_win][FIELD_W-1:0];
                        r_dsr <= (DW'(r_vsum[r_win]) << 1) + DW'(r_vsum[r_win]);
                    end else begin
                        r_avg[r_win] <= '0;
                        r_win <= r_win + 2'd1;
                        if (last_win) r_out_valid <= 1'b1;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_diff[DW-1:0] : div_r2[DW-1:0];
                    r_dvd <= {r_dvd[FIELD_W-2:0], 1'b0};
                    r_quo <= {r_quo[FIELD_W-2:0], div_ge};
                    r_cnt <= r_cnt + DIV_CNT_W'(1);
                    if (div_last) begin
                        r_avg[r_win] <= {r_quo[FIELD_W-2:0], div_ge};
                        r_win <= r_win + 2'd1;
                        if (last_win) r_out_valid <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_stall) r_out_valid <= 1'b0;
                end
                default: begin
                    r_win <= r_win;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_average_a = r_avg[0];
    assign o_average_b = r_avg[1];
    assign o_average_c = r_avg[2];
    assign o_average_d = r_avg[3];
    assign o_valid_a   = r_ok[0];
    assign o_valid_b   = r_ok[1];
    assign o_valid_c   = r_ok[2];
    assign o_valid_d   = r_ok[3];

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("input taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a bar");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dsr))
        else $error("divider remainder out of range");

    a_seen_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= WW'(MAX_WINDOW))
        else $error("bar count above ring depth");

endmodule

/* design/vwma_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vwma_ram #(
    parameter int WIDTH = 74,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
